### hdl/ising_spin_delta_energy_macros.svh
// Assertion shorthands shared by the block's modules.
// Both forms sample on clk and stay quiet while rst is high.
`ifndef ISING_SPIN_DELTA_ENERGY_MACROS_SVH
`define ISING_SPIN_DELTA_ENERGY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ISDE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isde assertion failed");
`define ISDE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isde assertion failed");
`else
`define ISDE_ASSERT_IMP(label, ante, cons)
`define ISDE_ASSERT_NXT(label, ante, cons)
`endif

`endif

### hdl/isde_pkg.sv
package isde_pkg;

  localparam int SITE_W   = 12;
  localparam int NSITES_W = 13;
  localparam int ACC_W    = 24;
  localparam int MAG_W    = 14;

  localparam logic [1:0] ACT_TERM  = 2'd0;
  localparam logic [1:0] ACT_FLIP  = 2'd1;
  localparam logic [1:0] ACT_SETUP = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;

  localparam logic [NSITES_W-1:0]      NSITES_RESET = 13'd4096;
  localparam logic signed [MAG_W-1:0]  MAG_RESET    = 14'sd4096;

  typedef enum logic [1:0] {
    OP_TERM,
    OP_FLIP,
    OP_SETUP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SITE_W-1:0] center;
    logic [SITE_W-1:0] neighbor;
    logic              last;
  } item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIN,
    S_SWEEP
  } state_t;

endpackage

### hdl/isde_front.sv
`include "ising_spin_delta_energy_macros.svh"

module isde_front #(
  parameter int COUPLING_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [1:0]                          action,
  input  logic [isde_pkg::SITE_W-1:0]         center_site,
  input  logic [isde_pkg::SITE_W-1:0]         neighbor_site,
  input  logic signed [COUPLING_BITS-1:0]     coupling,
  input  logic                                last_term,
  input  logic                                clearing,
  output logic                                q_valid,
  output isde_pkg::item_t                     q_item,
  output logic signed [COUPLING_BITS-1:0]     q_coupling,
  input  logic                                q_pop
);

  isde_pkg::item_t                   fifo_item [2];
  logic signed [COUPLING_BITS-1:0]   fifo_cpl  [2];
  logic                              wr_ptr;
  logic                              rd_ptr;
  logic [1:0]                        count;
  logic [1:0]                        count_next;
  logic                              accept;
  logic                              push;
  logic                              op_ok;
  isde_pkg::op_t                     op_dec;

  // Classify the action code; the unused code is taken and dropped.
  always_comb begin
    op_dec = isde_pkg::OP_TERM;
    op_ok  = 1'b1;
    unique case (action)
      isde_pkg::ACT_TERM:  op_dec = isde_pkg::OP_TERM;
      isde_pkg::ACT_FLIP:  op_dec = isde_pkg::OP_FLIP;
      isde_pkg::ACT_SETUP: op_dec = isde_pkg::OP_SETUP;
      default:             op_ok  = 1'b0;
    endcase
  end

  assign item_ready = (count != 2'd2) && !clearing;
  assign accept     = item_valid && item_ready;
  assign push       = accept && op_ok;
  assign q_valid    = (count != 2'd0);
  assign q_item     = fifo_item[rd_ptr];
  assign q_coupling = fifo_cpl[rd_ptr];

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_item[wr_ptr] <= '{op: op_dec, center: center_site, neighbor: neighbor_site,
                             last: last_term};
      fifo_cpl[wr_ptr]  <= coupling;
    end
  end

  `ISDE_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid)

endmodule

### hdl/isde_back.sv
`include "ising_spin_delta_energy_macros.svh"

module isde_back #(
  parameter int MAX_SITES     = 4096,
  parameter int COUPLING_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [isde_pkg::NSITES_W-1:0]        cfg_write_data,
  input  logic                                 q_valid,
  input  isde_pkg::item_t                      q_item,
  input  logic signed [COUPLING_BITS-1:0]      q_coupling,
  output logic                                 q_pop,
  output logic                                 clearing,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [isde_pkg::ACC_W-1:0]    delta_energy,
  output logic signed [isde_pkg::ACC_W-1:0]    partial_energy,
  output logic                                 center_spin,
  output logic signed [isde_pkg::MAG_W-1:0]    magnetization,
  output logic                                 saturated
);

  localparam int AW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int SUM_W = ((COUPLING_BITS > isde_pkg::ACC_W) ? COUPLING_BITS
                                                             : isde_pkg::ACC_W) + 1;
  localparam int ACC_W = isde_pkg::ACC_W;
  localparam int MAG_W = isde_pkg::MAG_W;

  // spin memory, 1 means +1
  logic                  mem [MAX_SITES];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_wdata;
  logic                  nbr_q;
  logic                  ctr_q;

  isde_pkg::state_t      state;
  isde_pkg::state_t      state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic                  clip;
  logic                  clip_next;
  logic signed [MAG_W-1:0] spin_sum;
  logic signed [MAG_W-1:0] spin_sum_next;
  logic [isde_pkg::NSITES_W-1:0] num_sites;

  isde_pkg::op_t                    cur_op;
  logic [isde_pkg::SITE_W-1:0]      cur_center;
  logic                             cur_last;
  logic signed [COUPLING_BITS-1:0]  cur_cpl;
  logic                             cur_ctr_hi;
  logic                             cur_nbr_hi;

  logic [CNT_W-1:0]      active;
  logic                  do_flip;
  logic                  ctr_spin;
  logic                  nbr_spin;
  logic                  out_free;
  logic                  load_out;
  logic signed [ACC_W-1:0] de_new;
  logic signed [ACC_W-1:0] pe_new;
  logic                  spin_new;
  logic signed [MAG_W-1:0] mag_new;
  logic                  sat_new;

  logic signed [SUM_W-1:0] cpl_ext;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [ACC_W+1:0] de_full;
  logic signed [ACC_W:0]   pe_full;
  logic                  de_clip;
  logic                  pe_clip;
  logic                  flip_commit;
  logic                  fin_commit;

  assign active = (32'(num_sites) >= 32'(MAX_SITES)) ? CNT_W'(MAX_SITES)
                                                     : CNT_W'(num_sites);
  assign do_flip  = 32'(cur_center) < 32'(active);
  assign ctr_spin = cur_ctr_hi | ctr_q;
  assign nbr_spin = cur_nbr_hi | nbr_q;
  assign out_free = !result_valid || result_ready;
  assign clearing = (state == isde_pkg::S_CLEAR);

  // Saturating accumulate of one neighbor term.
  always_comb begin
    cpl_ext = SUM_W'(cur_cpl);
    term    = nbr_spin ? cpl_ext : -cpl_ext;
    acc_sum = SUM_W'(acc) + term;
  end

  // Flip energy and bond energy from the finished local field.
  always_comb begin
    de_full = ctr_spin ? ((ACC_W+2)'(acc) <<< 1) : -((ACC_W+2)'(acc) <<< 1);
    pe_full = ctr_spin ? -((ACC_W+1)'(acc)) : (ACC_W+1)'(acc);
    de_clip = (de_full > (ACC_W+2)'(isde_pkg::ACC_MAX)) ||
              (de_full < (ACC_W+2)'(isde_pkg::ACC_MIN));
    pe_clip = (pe_full > (ACC_W+1)'(isde_pkg::ACC_MAX)) ||
              (pe_full < (ACC_W+1)'(isde_pkg::ACC_MIN));
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    acc_next      = acc;
    clip_next     = clip;
    spin_sum_next = spin_sum;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'(cnt);
    mem_wdata     = 1'b1;
    load_out      = 1'b0;
    de_new        = '0;
    pe_new        = '0;
    spin_new      = ctr_spin;
    mag_new       = spin_sum;
    sat_new       = 1'b0;
    unique case (state)
      isde_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == CNT_W'(MAX_SITES - 1)) begin
          cnt_next   = '0;
          state_next = isde_pkg::S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      isde_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = isde_pkg::S_EXEC;
        end
      end
      isde_pkg::S_EXEC: begin
        unique case (cur_op)
          isde_pkg::OP_TERM: begin
            if (acc_sum > SUM_W'(isde_pkg::ACC_MAX)) begin
              acc_next  = isde_pkg::ACC_MAX;
              clip_next = 1'b1;
            end else if (acc_sum < SUM_W'(isde_pkg::ACC_MIN)) begin
              acc_next  = isde_pkg::ACC_MIN;
              clip_next = 1'b1;
            end else begin
              acc_next = ACC_W'(acc_sum);
            end
            state_next = cur_last ? isde_pkg::S_FIN : isde_pkg::S_IDLE;
          end
          isde_pkg::OP_FLIP: begin
            if (out_free) begin
              if (do_flip) begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(cur_center);
                mem_wdata     = ~ctr_q;
                spin_sum_next = ctr_q ? spin_sum - MAG_W'(2) : spin_sum + MAG_W'(2);
                spin_new      = ~ctr_q;
              end
              mag_new    = spin_sum_next;
              load_out   = 1'b1;
              state_next = isde_pkg::S_IDLE;
            end
          end
          isde_pkg::OP_SETUP: begin
            cnt_next   = '0;
            state_next = isde_pkg::S_SWEEP;
          end
          default: state_next = isde_pkg::S_IDLE;
        endcase
      end
      isde_pkg::S_FIN: begin
        if (out_free) begin
          de_new = de_clip ? (de_full[ACC_W+1] ? isde_pkg::ACC_MIN : isde_pkg::ACC_MAX)
                           : ACC_W'(de_full);
          pe_new = pe_clip ? (pe_full[ACC_W] ? isde_pkg::ACC_MIN : isde_pkg::ACC_MAX)
                           : ACC_W'(pe_full);
          sat_new    = clip | de_clip | pe_clip;
          load_out   = 1'b1;
          acc_next   = '0;
          clip_next  = 1'b0;
          state_next = isde_pkg::S_IDLE;
        end
      end
      isde_pkg::S_SWEEP: begin
        if (cnt < active) begin
          mem_we   = 1'b1;
          cnt_next = cnt + 1'b1;
        end else if (out_free) begin
          spin_sum_next = MAG_W'(active);
          mag_new       = MAG_W'(active);
          spin_new      = ctr_spin | do_flip;
          load_out      = 1'b1;
          state_next    = isde_pkg::S_IDLE;
        end
      end
      default: state_next = isde_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isde_pkg::S_CLEAR;
      cnt       <= '0;
      acc       <= '0;
      clip      <= 1'b0;
      spin_sum  <= isde_pkg::MAG_RESET;
      num_sites <= isde_pkg::NSITES_RESET;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      acc      <= acc_next;
      clip     <= clip_next;
      spin_sum <= spin_sum_next;
      if (cfg_write_en) num_sites <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // Latch the popped word and read both of its sites.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      nbr_q      <= mem[AW'(q_item.neighbor)];
      ctr_q      <= mem[AW'(q_item.center)];
      cur_op     <= q_item.op;
      cur_center <= q_item.center;
      cur_last   <= q_item.last;
      cur_cpl    <= q_coupling;
      cur_ctr_hi <= 32'(q_item.center) >= 32'(MAX_SITES);
      cur_nbr_hi <= 32'(q_item.neighbor) >= 32'(MAX_SITES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      delta_energy   <= de_new;
      partial_energy <= pe_new;
      center_spin    <= spin_new;
      magnetization  <= mag_new;
      saturated      <= sat_new;
    end
  end

  assign flip_commit = (state == isde_pkg::S_EXEC) && (cur_op == isde_pkg::OP_FLIP) &&
                       out_free && do_flip;
  assign fin_commit  = (state == isde_pkg::S_FIN) && out_free;

  `ISDE_ASSERT_IMP(a_clear_quiet, state == isde_pkg::S_CLEAR, !result_valid && !q_pop)
  `ISDE_ASSERT_NXT(a_fin_resets_field, fin_commit, (acc == '0) && !clip)
  `ISDE_ASSERT_NXT(a_flip_moves_two, flip_commit, ((spin_sum - $past(spin_sum)) == MAG_W'(2)) || (($past(spin_sum) - spin_sum) == MAG_W'(2)))
  `ISDE_ASSERT_IMP(a_sweep_bound, state == isde_pkg::S_SWEEP, cnt <= active)

endmodule

### hdl/ising_spin_delta_energy.sv
// Channel Handshake           Payload
// item    item_valid/ready    action, center_site, neighbor_site, coupling, last_term
// result  result_valid/ready  delta_energy, partial_energy, center_spin, magnetization, saturated
// config  cfg_write_en        cfg_write_data (num_sites)
//
// A neighbor term reads both sites from the spin memory's two read ports when it is
// popped, then accumulates. A last term then passes through the FIN state for the
// energies, a flip waits for the result register to be free, and set-all-up writes
// one site per cycle over min(num_sites, MAX_SITES) sites. After reset the spin memory
// is set to +1 one site per cycle over all MAX_SITES sites, with item_ready low. A
// two-word queue and the result register let the input and output sides stall independently.
module ising_spin_delta_energy #(
  parameter int MAX_SITES     = 4096,
  parameter int COUPLING_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [isde_pkg::NSITES_W-1:0]        cfg_write_data,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [1:0]                           action,
  input  logic [isde_pkg::SITE_W-1:0]          center_site,
  input  logic [isde_pkg::SITE_W-1:0]          neighbor_site,
  input  logic signed [COUPLING_BITS-1:0]      coupling,
  input  logic                                 last_term,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [isde_pkg::ACC_W-1:0]    delta_energy,
  output logic signed [isde_pkg::ACC_W-1:0]    partial_energy,
  output logic                                 center_spin,
  output logic signed [isde_pkg::MAG_W-1:0]    magnetization,
  output logic                                 saturated
);

  logic                             q_valid;
  isde_pkg::item_t                  q_item;
  logic signed [COUPLING_BITS-1:0]  q_coupling;
  logic                             q_pop;
  logic                             clearing;

  isde_front #(
    .COUPLING_BITS (COUPLING_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .center_site   (center_site),
    .neighbor_site (neighbor_site),
    .coupling      (coupling),
    .last_term     (last_term),
    .clearing      (clearing),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_coupling    (q_coupling),
    .q_pop         (q_pop)
  );

  isde_back #(
    .MAX_SITES     (MAX_SITES),
    .COUPLING_BITS (COUPLING_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_coupling     (q_coupling),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .delta_energy   (delta_energy),
    .partial_energy (partial_energy),
    .center_spin    (center_spin),
    .magnetization  (magnetization),
    .saturated      (saturated)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LATTICE = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BUDGET = 50;
  // Action code the block ignores.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0]                      act;
    logic [isde_pkg::SITE_W-1:0]     ctr;
    logic [isde_pkg::SITE_W-1:0]     nbr;
    logic signed [15:0]              cpl;
    logic                            lst;
  } site_cmd_t;

  typedef struct {
    logic signed [isde_pkg::ACC_W-1:0] de;
    logic signed [isde_pkg::ACC_W-1:0] pe;
    logic                              spin;
    logic signed [isde_pkg::MAG_W-1:0] mag;
    logic                              sat;
  } energy_word_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [isde_pkg::NSITES_W-1:0] cfg_write_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [1:0] action = '0;
  logic [isde_pkg::SITE_W-1:0] center_site = '0;
  logic [isde_pkg::SITE_W-1:0] neighbor_site = '0;
  logic signed [15:0] coupling = '0;
  logic last_term = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [isde_pkg::ACC_W-1:0] delta_energy;
  logic signed [isde_pkg::ACC_W-1:0] partial_energy;
  logic center_spin;
  logic signed [isde_pkg::MAG_W-1:0] magnetization;
  logic saturated;

  ising_spin_delta_energy dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .center_site   (center_site),
    .neighbor_site (neighbor_site),
    .coupling      (coupling),
    .last_term     (last_term),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .delta_energy  (delta_energy),
    .partial_energy(partial_energy),
    .center_spin   (center_spin),
    .magnetization (magnetization),
    .saturated     (saturated)
  );

  // Model of the spin lattice.
  bit spins [LATTICE] = '{default: 1'b1};
  longint field_sum = 0;
  bit field_sat = 1'b0;
  logic signed [isde_pkg::MAG_W-1:0] mag_sum = isde_pkg::MAG_RESET;
  logic [isde_pkg::NSITES_W-1:0] sites_cfg = isde_pkg::NSITES_RESET;

  site_cmd_t site_cmds [$];
  energy_word_t energy_due [$];

  int err_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  logic item_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("tb_top mismatch: %s", msg);
  endtask

  function automatic longint acc_clip(input longint v);
    if (v > longint'(isde_pkg::ACC_MAX)) return longint'(isde_pkg::ACC_MAX);
    if (v < longint'(isde_pkg::ACC_MIN)) return longint'(isde_pkg::ACC_MIN);
    return v;
  endfunction

  function automatic void apply_site_cmd(input site_cmd_t c);
    longint raw;
    longint sk;
    longint de;
    longint pe;
    bit sat;
    int n;
    energy_word_t r;
    n = (sites_cfg < LATTICE) ? int'(sites_cfg) : LATTICE;
    r.de = '0;
    r.pe = '0;
    r.sat = 1'b0;
    case (c.act)
      isde_pkg::ACT_TERM: begin
        raw = field_sum + longint'(c.cpl) * (spins[c.nbr] ? 1 : -1);
        field_sum = acc_clip(raw);
        if (field_sum != raw) field_sat = 1'b1;
        if (c.lst) begin
          sk = spins[c.ctr] ? 1 : -1;
          sat = field_sat;
          de = acc_clip(2 * sk * field_sum);
          pe = acc_clip(-sk * field_sum);
          if (de != 2 * sk * field_sum || pe != -sk * field_sum) sat = 1'b1;
          r.de = 24'(de);
          r.pe = 24'(pe);
          r.sat = sat;
          r.spin = spins[c.ctr];
          r.mag = mag_sum;
          energy_due.push_back(r);
          field_sum = 0;
          field_sat = 1'b0;
        end
      end
      isde_pkg::ACT_FLIP: begin
        // sites outside the active count stay put
        if (c.ctr < n) begin
          mag_sum = 14'(mag_sum + (spins[c.ctr] ? -2 : 2));
          spins[c.ctr] = ~spins[c.ctr];
        end
        r.spin = spins[c.ctr];
        r.mag = mag_sum;
        energy_due.push_back(r);
      end
      isde_pkg::ACT_SETUP: begin
        for (int i = 0; i < n; i++) spins[i] = 1'b1;
        mag_sum = 14'(n);
        r.spin = spins[c.ctr];
        r.mag = mag_sum;
        energy_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Result check and input capture.
  always @(posedge clk) begin : check_results
    energy_word_t want;
    item_taken <= item_valid && item_ready;
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (energy_due.size() == 0) begin
          flag_error("result word with nothing pending");
        end else begin
          want = energy_due.pop_front();
          if (delta_energy !== want.de)
            flag_error($sformatf("delta_energy got %0d want %0d", delta_energy, want.de));
          if (partial_energy !== want.pe)
            flag_error($sformatf("partial_energy got %0d want %0d", partial_energy, want.pe));
          if (center_spin !== want.spin)
            flag_error($sformatf("center_spin got %0b want %0b", center_spin, want.spin));
          if (magnetization !== want.mag)
            flag_error($sformatf("magnetization got %0d want %0d", magnetization, want.mag));
          if (saturated !== want.sat)
            flag_error($sformatf("saturated got %0b want %0b", saturated, want.sat));
        end
      end
      if (cfg_write_en) sites_cfg = cfg_write_data;
      if (item_valid && item_ready)
        apply_site_cmd('{action, center_site, neighbor_site, coupling, last_term});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Sender: one word per handshake, random gaps between some words.
  int tx_gap = 0;
  int tx_calm = 0;
  bit tx_drain = 1'b0;

  always @(negedge clk) begin : send_words
    site_cmd_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_taken) begin
      // hold the word until taken
    end else if (tx_gap > 0) begin
      item_valid <= 1'b0;
      tx_gap--;
    end else if (tx_drain && energy_due.size() != 0) begin
      item_valid <= 1'b0;
    end else if (site_cmds.size() != 0) begin
      nxt = site_cmds.pop_front();
      action <= nxt.act;
      center_site <= nxt.ctr;
      neighbor_site <= nxt.nbr;
      coupling <= nxt.cpl;
      last_term <= nxt.lst;
      item_valid <= 1'b1;
      items_sent++;
      // pause now and then until every pending result is back
      tx_drain = (items_sent % 300 == 0);
      if (tx_calm > 0) begin
        tx_calm--;
        tx_gap = 0;
      end else if ($urandom_range(0, 99) < 2) begin
        tx_calm = $urandom_range(30, 120);
        tx_gap = 0;
      end else begin
        tx_gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
      end
    end else begin
      item_valid <= 1'b0;
    end
  end

  // Receiver: random stalls plus a long hold-off now and then.
  int rx_hold = 0;
  int rx_calm = 0;
  int rx_long_at = 120;

  always @(negedge clk) begin : take_words
    int r;
    r = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      result_ready <= 1'b0;
      rx_hold--;
    end else if (results_seen >= rx_long_at) begin
      rx_long_at = rx_long_at + 450;
      rx_hold = 400;
      result_ready <= 1'b0;
    end else if (rx_calm > 0) begin
      result_ready <= 1'b1;
      rx_calm--;
    end else if (r < 3) begin
      rx_calm = $urandom_range(30, 150);
      result_ready <= 1'b1;
    end else if (r < 30) begin
      rx_hold = pick_gap() - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic push_cmd(input logic [1:0] a, input int ctr, input int nbr, input int cpl,
                          input bit lst);
    site_cmd_t c;
    c.act = a;
    c.ctr = 12'(ctr);
    c.nbr = 12'(nbr);
    c.cpl = 16'(cpl);
    c.lst = lst;
    site_cmds.push_back(c);
  endtask

  function automatic int pick_site(input int n);
    if (n > 0 && $urandom_range(0, 3) != 0)
      return $urandom_range(0, ((n < LATTICE) ? n : LATTICE) - 1);
    return $urandom_range(0, LATTICE - 1);
  endfunction

  function automatic int pick_coupling();
    case ($urandom_range(0, 4))
      0, 1, 2: return int'($signed(16'($urandom)));
      3: return int'($urandom_range(0, 1023)) - 512;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32767;
          1: return -32768;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // One neighbor over and over so every term has the same sign.
  task automatic push_long_list(input int n, input int len);
    int ctr;
    int nbr;
    bit neg;
    ctr = pick_site(n);
    nbr = pick_site(n);
    neg = 1'($urandom_range(0, 1));
    for (int j = 0; j < len; j++) begin
      push_cmd(isde_pkg::ACT_TERM, ctr, nbr,
               neg ? -int'($urandom_range(30000, 32768)) : int'($urandom_range(30000, 32767)),
               j == len - 1);
    end
  endtask

  task automatic fill_phase(input int n, input int budget, input int long_len);
    int made;
    int k;
    int r;
    int ctr;
    made = 0;
    if (long_len > 0) begin
      push_long_list(n, long_len);
      made = long_len;
    end
    while (made < budget) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        k = $urandom_range(1, 6);
        ctr = pick_site(n);
        for (int j = 0; j < k; j++)
          push_cmd(isde_pkg::ACT_TERM, ctr, pick_site(n), pick_coupling(), j == k - 1);
        made += k;
        if ($urandom_range(0, 1) == 1) begin
          push_cmd(isde_pkg::ACT_FLIP, ctr, $urandom_range(0, LATTICE - 1), pick_coupling(),
                   1'($urandom));
          made++;
        end
      end else if (r < 74) begin
        push_cmd(isde_pkg::ACT_FLIP, pick_site(n), $urandom_range(0, LATTICE - 1),
                 pick_coupling(), 1'($urandom));
        made++;
      end else if (r < 77) begin
        push_cmd(isde_pkg::ACT_SETUP, $urandom_range(0, LATTICE - 1),
                 $urandom_range(0, LATTICE - 1), pick_coupling(), 1'($urandom));
        made++;
      end else if (r < 87) begin
        // list cut short: terms that never see their last
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++)
          push_cmd(isde_pkg::ACT_TERM, pick_site(n), pick_site(n), pick_coupling(), 1'b0);
        made += k;
      end else if (r < 92) begin
        push_cmd(ACT_SPARE, $urandom_range(0, LATTICE - 1), $urandom_range(0, LATTICE - 1),
                 pick_coupling(), 1'($urandom));
      end else begin
        push_cmd(isde_pkg::ACT_TERM, $urandom_range(0, LATTICE - 1),
                 $urandom_range(0, LATTICE - 1), pick_coupling(), 1'($urandom));
        made++;
      end
    end
  endtask

  task automatic write_sites(input int v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= 13'(v);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (site_cmds.size() != 0 || item_valid || energy_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int phase_sites [10] = '{4096, 1, 0, 8191, 2, 37, 300, 4095, 6, 4096};

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (phase_sites[p]) begin
      write_sites(phase_sites[p]);
      @(posedge clk);
      case (p)
        0: begin
          push_cmd(isde_pkg::ACT_TERM, 0, 4095, 32767, 1'b1);
          push_cmd(isde_pkg::ACT_TERM, 4095, 0, -32768, 1'b0);
          push_cmd(isde_pkg::ACT_TERM, 4095, 4095, -1, 1'b1);
          push_cmd(isde_pkg::ACT_FLIP, 0, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_FLIP, 4095, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_TERM, 0, 0, 256, 1'b1);
          push_cmd(ACT_SPARE, 4095, 4095, -1, 1'b1);
          // flip in the middle of a list leaves the field sum alone
          push_cmd(isde_pkg::ACT_TERM, 5, 4095, 100, 1'b0);
          push_cmd(isde_pkg::ACT_FLIP, 5, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_TERM, 5, 5, 0, 1'b1);
          push_cmd(isde_pkg::ACT_SETUP, 4095, 0, 0, 1'b0);
        end
        1: begin
          push_cmd(isde_pkg::ACT_FLIP, 0, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_FLIP, 1, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_FLIP, 4095, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_SETUP, 1, 0, 0, 1'b0);
        end
        2: begin
          push_cmd(isde_pkg::ACT_FLIP, 0, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_SETUP, 0, 0, 0, 1'b0);
        end
        3: begin
          push_cmd(isde_pkg::ACT_SETUP, 4095, 0, 0, 1'b0);
          push_cmd(isde_pkg::ACT_FLIP, 4095, 0, 0, 1'b0);
        end
        default: ;
      endcase
      fill_phase(phase_sites[p], PHASE_BUDGET, (p == 4) ? 300 : (p == 7) ? 170 : 0);
      wait_idle();
    end
    if (energy_due.size() != 0)
      flag_error($sformatf("%0d result words never arrived", energy_due.size()));
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule
